### sv/detection_row_argmax_box_decode_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the detection row argmax and box decode block.
// Each macro makes one named, clocked assertion that is off during reset.
// ----------------------------------------------------------------------------
`ifndef DETECTION_ROW_ARGMAX_BOX_DECODE_TOP_ASSERT_SVH
`define DETECTION_ROW_ARGMAX_BOX_DECODE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRABD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRABD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

### sv/drabd_pkg.sv
// ----------------------------------------------------------------------------
// drabd_pkg
// Shared widths, reset values and register codes of the row decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drabd_pkg;

	localparam int MAX_CLASSES_DEF = 256;
	localparam int BOX_FIELDS      = 4;

	localparam int VAL_W   = 18;
	localparam int SCALE_W = 14;
	localparam int CC_W    = 9;
	localparam int PX_W    = 15;
	localparam int IDX_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	localparam logic signed [VAL_W-1:0] THRESHOLD_RST = 18'sd32768;
	localparam logic [SCALE_W-1:0]      IMAGE_W_RST   = 14'd640;
	localparam logic [SCALE_W-1:0]      IMAGE_H_RST   = 14'd640;
	localparam logic [CC_W-1:0]         CLASS_CNT_RST = 9'd80;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCORE_THRESHOLD = 2'd0,
		CFG_IMAGE_WIDTH     = 2'd1,
		CFG_IMAGE_HEIGHT    = 2'd2,
		CFG_CLASS_COUNT     = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

### sv/detection_row_argmax_box_decode_top.sv
// ----------------------------------------------------------------------------
// detection_row_argmax_box_decode_top: per-row class argmax and box decode
// Throughput: one tensor item per cycle, set by the running compare, unless an output stall backs up to stage 1.
// A box passes through stages 2 and 3 and the output register after its row's last score leaves stage 1.
// Reset (arst_n low) clears the pipeline, row state and registers to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module detection_row_argmax_box_decode_top #(
	parameter int MAX_CLASSES = drabd_pkg::MAX_CLASSES_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	// Tensor item stream.
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic signed [drabd_pkg::VAL_W-1:0]       value,
	input  wire logic                                     frame_end,
	// Decoded box stream.
	output logic                                          out_valid,
	input  wire logic                                     out_stall,
	output logic signed [drabd_pkg::PX_W-1:0]             box_left,
	output logic signed [drabd_pkg::PX_W-1:0]             box_top,
	output logic signed [drabd_pkg::PX_W-1:0]             box_width,
	output logic signed [drabd_pkg::PX_W-1:0]             box_height,
	output logic [drabd_pkg::IDX_W-1:0]                   class_index,
	output logic signed [drabd_pkg::VAL_W-1:0]            best_score,
	// Register write port.
	input  wire logic                                     cfg_valid,
	output logic                                          cfg_ready,
	input  wire logic [drabd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [drabd_pkg::CFG_DATA_W-1:0]         cfg_data
);

	// The pipeline has four register stages. Stage 1 holds the accepted
	// item; the row state (position, box values, running maximum) is updated
	// as that item leaves stage 1. Only items that complete a row with a
	// passing score go on: stage 2 keeps a copy of the row's box, stage 3
	// holds the four scaled products, and the output register holds the
	// rounded, saturated box. Each stage refills while the one after it
	// drains, so a waiting result does not hold up the stream until every
	// stage behind it is full.

	localparam int BF     = drabd_pkg::BOX_FIELDS;
	localparam int VAL_W  = drabd_pkg::VAL_W;
	localparam int PX_W   = drabd_pkg::PX_W;
	localparam int IDX_W  = drabd_pkg::IDX_W;
	localparam int CC_W   = drabd_pkg::CC_W;
	localparam int SC_W   = drabd_pkg::SCALE_W;
	// Row position runs up to MAX_CLASSES + BOX_FIELDS - 1.
	localparam int POS_W  = $clog2(MAX_CLASSES + BF);
	localparam int CMP_W  = ((POS_W > CC_W) ? POS_W : CC_W) + 1;
	localparam int EDGE_W = VAL_W + 2;
	localparam int PROD_W = EDGE_W + SC_W + 1;
	localparam int SIZE_W = VAL_W + SC_W + 1;
	localparam int EDGE_SH = 17;
	localparam int SIZE_SH = 16;

	// Exact product, truncated toward zero after a right shift, then
	// saturated to the pixel field range.
	function automatic logic signed [PX_W-1:0] round_sat(
		input logic signed [PROD_W-1:0] p,
		input int                       sh
	);
		logic signed [PROD_W:0] biased;
		logic signed [PROD_W:0] q;
		logic signed [PROD_W:0] lim_hi;
		logic signed [PROD_W:0] lim_lo;
		biased = {p[PROD_W-1], p};
		if (p[PROD_W-1]) begin
			biased = biased + (((PROD_W+1)'(1)) << sh) - (PROD_W+1)'(1);
		end
		q = biased >>> sh;
		lim_hi = (PROD_W+1)'((1 << (PX_W-1)) - 1);
		lim_lo = -((PROD_W+1)'(1 << (PX_W-1)));
		if (q > lim_hi) begin
			return PX_W'(lim_hi);
		end else if (q < lim_lo) begin
			return PX_W'(lim_lo);
		end
		return PX_W'(q);
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken.
	// ------------------------------------------------------------------
	logic signed [VAL_W-1:0] thr_q;
	logic [SC_W-1:0]         img_w_q;
	logic [SC_W-1:0]         img_h_q;
	logic [CC_W-1:0]         class_cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= drabd_pkg::THRESHOLD_RST;
			img_w_q     <= drabd_pkg::IMAGE_W_RST;
			img_h_q     <= drabd_pkg::IMAGE_H_RST;
			class_cnt_q <= drabd_pkg::CLASS_CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (drabd_pkg::cfg_reg_t'(cfg_index))
				drabd_pkg::CFG_SCORE_THRESHOLD: thr_q       <= signed'(cfg_data[VAL_W-1:0]);
				drabd_pkg::CFG_IMAGE_WIDTH:     img_w_q     <= cfg_data[SC_W-1:0];
				drabd_pkg::CFG_IMAGE_HEIGHT:    img_h_q     <= cfg_data[SC_W-1:0];
				drabd_pkg::CFG_CLASS_COUNT:     class_cnt_q <= cfg_data[CC_W-1:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage handshakes. A stage is free when it is empty or drains now.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic out_free, s3_free, s2_free, s1_fire, s1_free, in_accept;
	logic emit;

	assign out_free  = !out_valid || !out_stall;
	assign s3_free   = !valid_s3 || out_free;
	assign s2_free   = !valid_s2 || s3_free;
	assign s1_fire   = valid_s1 && (!emit || s2_free);
	assign s1_free   = !valid_s1 || s1_fire;
	assign in_stall  = !s1_free;
	assign in_accept = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Stage 1: the accepted item.
	// ------------------------------------------------------------------
	logic signed [VAL_W-1:0] value_s1;
	logic                    frame_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			value_s1     <= value;
			frame_end_s1 <= frame_end;
		end
	end

	// ------------------------------------------------------------------
	// Row state and the running maximum.
	// ------------------------------------------------------------------
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] box_q [BF];
	logic signed [VAL_W-1:0] best_q;
	logic [IDX_W-1:0]        best_idx_q;

	logic [CMP_W-1:0]        classes_eff;
	logic [CMP_W-1:0]        last_pos;
	logic [POS_W-1:0]        pos_eff;
	logic [CMP_W-1:0]        cls;
	logic                    is_box, is_last, take_new;
	logic signed [VAL_W-1:0] best_nxt;
	logic [IDX_W-1:0]        best_idx_nxt;

	always_comb begin
		// A class count of zero means one class; counts above the build
		// limit are held to the limit.
		if (class_cnt_q == '0) begin
			classes_eff = CMP_W'(1);
		end else if (CMP_W'(class_cnt_q) > CMP_W'(MAX_CLASSES)) begin
			classes_eff = CMP_W'(MAX_CLASSES);
		end else begin
			classes_eff = CMP_W'(class_cnt_q);
		end
		last_pos = classes_eff + CMP_W'(BF - 1);
		// A position left past the row end by a smaller class count
		// starts a fresh row.
		pos_eff  = (CMP_W'(pos_q) > last_pos) ? '0 : pos_q;
		is_box   = CMP_W'(pos_eff) < CMP_W'(BF);
		is_last  = CMP_W'(pos_eff) == last_pos;
		cls      = CMP_W'(pos_eff) - CMP_W'(BF);
		take_new = !is_box && ((cls == '0) || (value_s1 > best_q));
		best_nxt     = take_new ? value_s1 : best_q;
		best_idx_nxt = take_new ? cls[IDX_W-1:0] : best_idx_q;
		emit     = is_last && (best_nxt >= thr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			for (int i = 0; i < BF; i++) begin
				box_q[i] <= '0;
			end
		end else if (s1_fire) begin
			if (is_box) begin
				box_q[pos_eff[1:0]] <= value_s1;
			end
			best_q     <= best_nxt;
			best_idx_q <= best_idx_nxt;
			if (is_last || frame_end_s1) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_eff + POS_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: a copy of the finished row.
	// ------------------------------------------------------------------
	logic signed [VAL_W-1:0] cx_s2, cy_s2, w_s2, h_s2, score_s2;
	logic [IDX_W-1:0]        idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			cx_s2    <= box_q[0];
			cy_s2    <= box_q[1];
			w_s2     <= box_q[2];
			h_s2     <= box_q[3];
			score_s2 <= best_nxt;
			idx_s2   <= best_idx_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: scaled products. Edges use (2*center - size) in Q17 so
	// that the half-size term stays exact.
	// ------------------------------------------------------------------
	logic signed [EDGE_W-1:0] edge_x, edge_y;
	logic signed [SC_W:0]     scale_w, scale_h;
	logic signed [PROD_W-1:0] prod_l, prod_t;
	logic signed [SIZE_W-1:0] prod_w, prod_h;
	logic signed [PROD_W-1:0] left_s3, top_s3, wid_s3, hgt_s3;
	logic signed [VAL_W-1:0]  score_s3;
	logic [IDX_W-1:0]         idx_s3;

	always_comb begin
		scale_w = signed'({1'b0, img_w_q});
		scale_h = signed'({1'b0, img_h_q});
		edge_x  = (EDGE_W'(cx_s2) <<< 1) - EDGE_W'(w_s2);
		edge_y  = (EDGE_W'(cy_s2) <<< 1) - EDGE_W'(h_s2);
		prod_l  = edge_x * scale_w;
		prod_t  = edge_y * scale_h;
		prod_w  = w_s2 * scale_w;
		prod_h  = h_s2 * scale_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && s3_free) begin
			left_s3  <= prod_l;
			top_s3   <= prod_t;
			wid_s3   <= PROD_W'(prod_w);
			hgt_s3   <= PROD_W'(prod_h);
			score_s3 <= score_s2;
			idx_s3   <= idx_s2;
		end
	end

	// ------------------------------------------------------------------
	// Output register: truncate toward zero and saturate.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && out_free) begin
			box_left    <= round_sat(left_s3, EDGE_SH);
			box_top     <= round_sat(top_s3, EDGE_SH);
			box_width   <= round_sat(wid_s3, SIZE_SH);
			box_height  <= round_sat(hgt_s3, SIZE_SH);
			class_index <= idx_s3;
			best_score  <= score_s3;
		end
	end

endmodule

`default_nettype wire

### sv/drabd_checker.sv
// ----------------------------------------------------------------------------
// drabd_checker
// Port-level checks of the row decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "detection_row_argmax_box_decode_top_assert.svh"

module drabd_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_stall,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic signed [drabd_pkg::PX_W-1:0]   box_left,
	input wire logic signed [drabd_pkg::PX_W-1:0]   box_top,
	input wire logic signed [drabd_pkg::PX_W-1:0]   box_width,
	input wire logic signed [drabd_pkg::PX_W-1:0]   box_height,
	input wire logic [drabd_pkg::IDX_W-1:0]         class_index,
	input wire logic signed [drabd_pkg::VAL_W-1:0]  best_score,
	input wire logic                                cfg_valid,
	input wire logic                                cfg_ready,
	input wire logic [drabd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input wire logic [drabd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int OUT_BUS_W = 4 * drabd_pkg::PX_W + drabd_pkg::IDX_W + drabd_pkg::VAL_W;

	// Shadow of the score threshold, followed from the write port.
	logic signed [drabd_pkg::VAL_W-1:0] thr_q;
	logic                               out_hold;
	logic [OUT_BUS_W-1:0]               out_bus;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= drabd_pkg::THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready &&
				cfg_index == drabd_pkg::CFG_SCORE_THRESHOLD) begin
			thr_q <= signed'(cfg_data[drabd_pkg::VAL_W-1:0]);
		end
	end

	assign out_hold = out_valid && out_stall;
	// All result fields side by side, so one check covers the whole item.
	assign out_bus  = {box_left, box_top, box_width, box_height, class_index, best_score};

	`DRABD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_hold, out_valid && $stable(out_bus), "stalled result changed")
	`DRABD_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, out_hold, "input stalled, no result waiting")
	`DRABD_ASSERT_SAME(a_score_pass, clk, arst_n, out_valid, best_score >= thr_q, "result below threshold")
	`DRABD_ASSERT_SAME(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "register write port not ready")

endmodule

bind detection_row_argmax_box_decode_top drabd_checker u_drabd_checker (.*);

`default_nettype wire
